// File: rtl/keyword_tokenizer_top_defines.svh
// Assertion macros shared by the keyword tokenizer RTL
`ifndef KEYWORD_TOKENIZER_TOP_DEFINES_SVH
`define KEYWORD_TOKENIZER_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset
`define KT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next, outside reset
`define KT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kt_pkg.sv
// Package: codes, keyword table and character classes for the keyword tokenizer
package kt_pkg;

    // Default build-time settings
    localparam int MAX_TOKEN_LEN_DEF = 64;
    localparam int POSITION_BITS_DEF = 16;
    localparam int OUTQ_DEPTH        = 4;

    // Input operation codes
    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Token kinds
    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_STRING  = 3'd3;
    localparam logic [2:0] KIND_OPER    = 3'd4;
    localparam logic [2:0] KIND_PUNCT   = 3'd5;
    localparam logic [2:0] KIND_UNTERM  = 3'd6;

    localparam logic [3:0] NO_KW = 4'd9;

    // Scanner mode
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_STR
    } scan_mode_t;

    // Results pushed into the output queue for one accepted item
    typedef struct packed {
        logic one;
        logic two;
    } kt_push_t;

    // Keywords in list order, right-aligned in 48 bits
    localparam int NUM_KW = 9;
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        "dg", "dgpr", "if", "else", "while", "for", "do", "def", "return"
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd2, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd3, 3'd6
    };

    // Character i of keyword k; zero past its end
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
        logic [47:0] word;
        int          sh;
        word = KW_TEXT[k];
        sh   = (int'(KW_LEN[k]) - 1 - int'(i)) * 8;
        if (sh < 0) begin
            kw_char = 8'h00;
        end else begin
            kw_char = word[sh +: 8];
        end
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0" && c <= "9");
    endfunction

    // Space, tab, line feed, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        is_quote = (c == "\"");
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        is_oper = (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
                  (c == "=") || (c == "<") || (c == ">");
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        is_punct = (c == "(") || (c == ")") || (c == "{") || (c == "}");
    endfunction

endpackage

// File: rtl/kt_scan.sv
// Scanner: classifies each byte, tracks the open token and builds up to two results
`include "keyword_tokenizer_top_defines.svh"

module kt_scan #(
    parameter int MAX_TOKEN_LEN = kt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = kt_pkg::POSITION_BITS_DEF,
    localparam int LEN_BITS     = $clog2(MAX_TOKEN_LEN + 1),
    localparam int RES_BITS     = 9 + POSITION_BITS + LEN_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                op,
    input  logic [7:0]          ch,
    output kt_pkg::kt_push_t    push,
    output logic [RES_BITS-1:0] entry0,
    output logic [RES_BITS-1:0] entry1
);

    localparam logic [kt_pkg::NUM_KW-1:0] ALL_ALIVE = '1;

    kt_pkg::scan_mode_t         mode_reg, mode_next;
    logic [kt_pkg::NUM_KW-1:0]  alive_reg, alive_next;
    logic [POSITION_BITS-1:0]   start_reg, start_next;
    logic [LEN_BITS-1:0]        len_reg, len_next;
    logic                       clip_reg, clip_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;

    logic [kt_pkg::NUM_KW-1:0]  ext_alive, first_alive;
    logic [LEN_BITS-1:0]        ext_len;
    logic                       ext_clip;
    logic                       kw_hit;
    logic [3:0]                 kw_idx;
    logic                       cont, str_close;
    logic                       close_v, tok_v;
    logic [2:0]                 close_kind, tok_kind;
    logic [3:0]                 close_kw;

    // Keyword match on the open word and its extension by the current byte
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = kt_pkg::NO_KW;
        for (int k = kt_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (alive_reg[k] && len_reg == LEN_BITS'(kt_pkg::KW_LEN[k])) begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
            end
            ext_alive[k]   = alive_reg[k] && (len_reg < LEN_BITS'(kt_pkg::KW_LEN[k])) &&
                             (kt_pkg::kw_char(k, len_reg[2:0]) == ch);
            first_alive[k] = (kt_pkg::kw_char(k, 3'd0) == ch);
        end
    end

    // Saturating length step
    always_comb begin
        if (len_reg >= LEN_BITS'(MAX_TOKEN_LEN)) begin
            ext_len  = len_reg;
            ext_clip = 1'b1;
        end else begin
            ext_len  = len_reg + LEN_BITS'(1);
            ext_clip = clip_reg;
        end
    end

    // Kind of the token closed by this item
    always_comb begin
        close_kw = kt_pkg::NO_KW;
        unique case (mode_reg)
            kt_pkg::MODE_WORD: begin
                if (kw_hit && !clip_reg) begin
                    close_kind = kt_pkg::KIND_KEYWORD;
                    close_kw   = kw_idx;
                end else begin
                    close_kind = kt_pkg::KIND_IDENT;
                end
            end
            kt_pkg::MODE_NUM: close_kind = kt_pkg::KIND_NUMBER;
            kt_pkg::MODE_STR: close_kind = (op == kt_pkg::OP_FLUSH) ? kt_pkg::KIND_UNTERM
                                                                     : kt_pkg::KIND_STRING;
            default:          close_kind = kt_pkg::KIND_IDENT;
        endcase
    end

    // Next state and result strobes
    always_comb begin
        mode_next  = mode_reg;
        alive_next = alive_reg;
        start_next = start_reg;
        len_next   = len_reg;
        clip_next  = clip_reg;
        pos_next   = pos_reg;
        close_v    = 1'b0;
        tok_v      = 1'b0;
        tok_kind   = kt_pkg::KIND_OPER;
        cont       = 1'b0;
        str_close  = 1'b0;

        unique case (mode_reg)
            kt_pkg::MODE_STR:  str_close = kt_pkg::is_quote(ch);
            kt_pkg::MODE_WORD: cont = kt_pkg::is_letter(ch) || kt_pkg::is_digit(ch);
            kt_pkg::MODE_NUM:  cont = kt_pkg::is_digit(ch);
            kt_pkg::MODE_IDLE: cont = 1'b0;
            default:           cont = 1'b0;
        endcase

        if (accept) begin
            if (op == kt_pkg::OP_FLUSH) begin
                // Flush: emit any open token, return to reset state
                close_v    = (mode_reg != kt_pkg::MODE_IDLE);
                mode_next  = kt_pkg::MODE_IDLE;
                alive_next = ALL_ALIVE;
                start_next = '0;
                len_next   = '0;
                clip_next  = 1'b0;
                pos_next   = '0;
            end else begin
                pos_next = pos_reg + POSITION_BITS'(1);
                if (mode_reg == kt_pkg::MODE_STR && !str_close) begin
                    len_next  = ext_len;
                    clip_next = ext_clip;
                end else if (str_close) begin
                    close_v    = 1'b1;
                    mode_next  = kt_pkg::MODE_IDLE;
                    alive_next = ALL_ALIVE;
                    len_next   = '0;
                    clip_next  = 1'b0;
                end else if (cont) begin
                    if (mode_reg == kt_pkg::MODE_WORD) begin
                        alive_next = ext_alive;
                    end
                    len_next  = ext_len;
                    clip_next = ext_clip;
                end else begin
                    // Close whatever is open, then treat the byte as from idle
                    close_v    = (mode_reg != kt_pkg::MODE_IDLE);
                    mode_next  = kt_pkg::MODE_IDLE;
                    alive_next = ALL_ALIVE;
                    len_next   = '0;
                    clip_next  = 1'b0;
                    if (kt_pkg::is_space(ch)) begin
                        mode_next = kt_pkg::MODE_IDLE;
                    end else if (kt_pkg::is_letter(ch)) begin
                        mode_next  = kt_pkg::MODE_WORD;
                        alive_next = first_alive;
                        start_next = pos_reg;
                        len_next   = LEN_BITS'(1);
                    end else if (kt_pkg::is_digit(ch)) begin
                        mode_next  = kt_pkg::MODE_NUM;
                        start_next = pos_reg;
                        len_next   = LEN_BITS'(1);
                    end else if (kt_pkg::is_quote(ch)) begin
                        mode_next  = kt_pkg::MODE_STR;
                        start_next = pos_reg + POSITION_BITS'(1);
                    end else if (kt_pkg::is_oper(ch)) begin
                        tok_v    = 1'b1;
                        tok_kind = kt_pkg::KIND_OPER;
                    end else if (kt_pkg::is_punct(ch)) begin
                        tok_v    = 1'b1;
                        tok_kind = kt_pkg::KIND_PUNCT;
                    end
                end
            end
        end
    end

    // Pack results, closed token first; last flag on the final one
    assign push.one = close_v || tok_v;
    assign push.two = close_v && tok_v;

    always_comb begin
        if (close_v) begin
            entry0 = {!tok_v, clip_reg, len_reg, start_reg, close_kw, close_kind};
        end else begin
            entry0 = {1'b1, 1'b0, LEN_BITS'(1), pos_reg, kt_pkg::NO_KW, tok_kind};
        end
        entry1 = {1'b1, 1'b0, LEN_BITS'(1), pos_reg, kt_pkg::NO_KW, tok_kind};
    end

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= kt_pkg::MODE_IDLE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // Open token and position registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= ALL_ALIVE;
            start_reg <= '0;
            len_reg   <= '0;
            clip_reg  <= 1'b0;
            pos_reg   <= '0;
        end else begin
            alive_reg <= alive_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            clip_reg  <= clip_next;
            pos_reg   <= pos_next;
        end
    end

    `KT_ASSERT(a_idle_clear, (mode_reg == kt_pkg::MODE_IDLE) |-> (len_reg == '0 && !clip_reg), "idle with token length or clip set")
    `KT_ASSERT_NEXT(a_flush_restart, accept && op == kt_pkg::OP_FLUSH, pos_reg == '0 && mode_reg == kt_pkg::MODE_IDLE, "flush did not restart scanner")
    `KT_ASSERT(a_two_needs_one, push.two |-> push.one, "second result without first")

endmodule

// File: rtl/kt_outq.sv
// Output queue: takes up to two results per cycle, hands out one per transfer
`include "keyword_tokenizer_top_defines.svh"

module kt_outq #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = kt_pkg::OUTQ_DEPTH,
    localparam int PTR_BITS = $clog2(DEPTH),
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  kt_pkg::kt_push_t push,
    input  logic [WIDTH-1:0] entry0,
    input  logic [WIDTH-1:0] entry1,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next, wr_plus1;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                pop;
    logic [1:0]          n_push;

    // Room for a full pair of results
    assign in_ready  = (count_reg <= CNT_BITS'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = {1'b0, push.one} + {1'b0, push.two};
    assign wr_plus1  = wr_reg + PTR_BITS'(1);

    // Advance pointers and fill count
    always_comb begin
        wr_next    = wr_reg + PTR_BITS'(n_push);
        rd_next    = pop ? rd_reg + PTR_BITS'(1) : rd_reg;
        count_next = count_reg + CNT_BITS'(n_push) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Store results
    always_ff @(posedge aclk) begin
        if (push.one) begin
            slot_reg[wr_reg] <= entry0;
        end
        if (push.two) begin
            slot_reg[wr_plus1] <= entry1;
        end
    end

    `KT_ASSERT(a_count_bound, count_reg <= CNT_BITS'(DEPTH), "queue count beyond depth")
    `KT_ASSERT(a_push_room, push.one |-> in_ready, "result pushed without room")

endmodule

// File: rtl/keyword_tokenizer_top.sv
// A result is queued when its token ends, then offered on m_tvalid. Throughput: one byte
// per cycle while the queue has room for two results; a byte that closes a word or number
// and is itself an operator or bracket gives two results, and the single-result-per-cycle
// output port then sets the pace (the four-entry output queue absorbs short bursts).
// Reset: synchronous, active low; clears scanner state, position count and the queue.
module keyword_tokenizer_top #(
    parameter int MAX_TOKEN_LEN = kt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = kt_pkg::POSITION_BITS_DEF,
    localparam int LEN_BITS     = $clog2(MAX_TOKEN_LEN + 1),
    localparam int RES_BITS     = 9 + POSITION_BITS + LEN_BITS,
    localparam int PAY_BITS     = 5 + POSITION_BITS + LEN_BITS,
    localparam int M_DATA_BITS  = ((PAY_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // character
    input  logic                   s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,   // keyword_id, start_position, token_length,
                                              // overlong, zero fill
    output logic [2:0]             m_tuser,   // token_kind
    output logic                   m_tlast    // last_in_run
);

    kt_pkg::kt_push_t    push;
    logic [RES_BITS-1:0] entry0, entry1, q_data;
    logic                accept;

    assign accept = s_tvalid && s_tready;

    kt_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .op      (s_tuser),
        .ch      (s_tdata),
        .push    (push),
        .entry0  (entry0),
        .entry1  (entry1)
    );

    kt_outq #(
        .WIDTH (RES_BITS),
        .DEPTH (kt_pkg::OUTQ_DEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .entry0    (entry0),
        .entry1    (entry1),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_data)
    );

    // Unpack the queued result onto the master side
    assign m_tuser = q_data[2:0];
    assign m_tdata = M_DATA_BITS'(q_data[RES_BITS-2:3]);
    assign m_tlast = q_data[RES_BITS-1];

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the keyword tokenizer: directed table and random text
`timescale 1ns / 1ps

module tb_top;

    localparam int         CLIP_LEN   = kt_pkg::MAX_TOKEN_LEN_DEF;
    localparam int         ITEM_GOAL  = 1650;
    localparam int         CALM_FROM  = 1450;
    localparam int         ROW_COUNT  = 25;
    localparam logic [7:0] QUOTE      = 8'h22;
    localparam logic [7:0] BLANK      = 8'h20;

    // One emitted token as it leaves the block
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  kw;
        logic [15:0] start;
        logic [6:0]  len;
        logic        over;
        logic        last;
    } token_t;

    // One row of the directed table: the byte, and a typed token where one is obvious
    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       typed;
        token_t     want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Tokens still owed by the block, oldest first
    token_t      pending_tokens[$];

    // Shadow scanner
    kt_pkg::scan_mode_t lx_mode;
    logic [15:0] lx_pos;
    logic [15:0] lx_start;
    logic [6:0]  lx_len;
    logic        lx_clip;
    logic [7:0]  lx_text [0:5];
    token_t      fresh [0:1];
    int          fresh_n;

    bit          calm = 1'b0;
    int          n_errors = 0;
    int          n_items = 0;
    int          n_live = 0;
    int          n_flush = 0;
    int          n_checked = 0;
    int          n_overlong = 0;
    int          kind_seen [0:6];
    int          stall_left = 0;

    keyword_tokenizer_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Character classes
    function automatic logic is_blank(input logic [7:0] c);
        return (c == BLANK) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == "<" || c == ">";
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}";
    endfunction

    function automatic string kw_name(input int k);
        case (k)
            0:       return "dg";
            1:       return "dgpr";
            2:       return "if";
            3:       return "else";
            4:       return "while";
            5:       return "for";
            6:       return "do";
            7:       return "def";
            default: return "return";
        endcase
    endfunction

    // True when the open word spells keyword k exactly
    function automatic logic word_is(input int k);
        string name;
        name = kw_name(k);
        if (name.len() != int'(lx_len)) return 1'b0;
        for (int i = 0; i < name.len(); i++) begin
            if (name[i] != lx_text[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_scanner();
        lx_mode  = kt_pkg::MODE_IDLE;
        lx_pos   = '0;
        lx_start = '0;
        lx_len   = '0;
        lx_clip  = 1'b0;
    endfunction

    function automatic void open_token(input kt_pkg::scan_mode_t mode, input logic [15:0] at);
        lx_mode  = mode;
        lx_start = at;
        lx_len   = '0;
        lx_clip  = 1'b0;
    endfunction

    // Add one value byte; hold the length at the clip limit
    function automatic void grow(input logic [7:0] ch);
        if (lx_mode == kt_pkg::MODE_WORD && lx_len < 7'd6) lx_text[lx_len] = ch;
        if (int'(lx_len) >= CLIP_LEN) lx_clip = 1'b1;
        else lx_len = lx_len + 7'd1;
    endfunction

    // Close whatever is open; returns 0 when nothing was open
    function automatic logic close_token(input logic at_end, output token_t tok);
        tok = '0;
        if (lx_mode == kt_pkg::MODE_IDLE) return 1'b0;
        tok.kw    = kt_pkg::NO_KW;
        tok.start = lx_start;
        tok.len   = lx_len;
        tok.over  = lx_clip;
        case (lx_mode)
            kt_pkg::MODE_WORD: begin
                tok.kind = kt_pkg::KIND_IDENT;
                for (int k = 0; k < kt_pkg::NUM_KW; k++) begin
                    if (!lx_clip && tok.kind == kt_pkg::KIND_IDENT && word_is(k)) begin
                        tok.kind = kt_pkg::KIND_KEYWORD;
                        tok.kw   = 4'(k);
                    end
                end
            end
            kt_pkg::MODE_NUM: tok.kind = kt_pkg::KIND_NUMBER;
            default:          tok.kind = at_end ? kt_pkg::KIND_UNTERM : kt_pkg::KIND_STRING;
        endcase
        lx_mode = kt_pkg::MODE_IDLE;
        lx_len  = '0;
        lx_clip = 1'b0;
        return 1'b1;
    endfunction

    function automatic token_t one_byte(input logic [2:0] kind, input logic [15:0] at);
        token_t tok;
        tok       = '0;
        tok.kind  = kind;
        tok.kw    = kt_pkg::NO_KW;
        tok.start = at;
        tok.len   = 7'd1;
        return tok;
    endfunction

    // Append one token to those released by the current item
    function automatic void book(input token_t tok);
        fresh[fresh_n] = tok;
        fresh_n++;
    endfunction

    // Work out the tokens that one accepted item releases
    function automatic void scan_item(input logic op, input logic [7:0] ch);
        token_t      tok;
        logic [15:0] here;
        fresh_n = 0;
        here    = lx_pos;
        if (op == kt_pkg::OP_FLUSH) begin
            if (close_token(1'b1, tok)) book(tok);
            clear_scanner();
        end else begin
            if (lx_mode == kt_pkg::MODE_STR) begin
                if (ch == QUOTE) begin
                    if (close_token(1'b0, tok)) book(tok);
                end else begin
                    grow(ch);
                end
            end else if ((lx_mode == kt_pkg::MODE_WORD && (is_alpha(ch) || is_num(ch))) ||
                         (lx_mode == kt_pkg::MODE_NUM && is_num(ch))) begin
                grow(ch);
            end else begin
                // the ending byte is then taken as if nothing were open
                if (close_token(1'b0, tok)) book(tok);
                if (is_alpha(ch)) begin
                    open_token(kt_pkg::MODE_WORD, here);
                    grow(ch);
                end else if (is_num(ch)) begin
                    open_token(kt_pkg::MODE_NUM, here);
                    grow(ch);
                end else if (ch == QUOTE) begin
                    open_token(kt_pkg::MODE_STR, here + 16'd1);
                end else if (is_op(ch)) begin
                    book(one_byte(kt_pkg::KIND_OPER, here));
                end else if (is_bracket(ch)) begin
                    book(one_byte(kt_pkg::KIND_PUNCT, here));
                end
            end
            lx_pos = here + 16'd1;
        end
        if (fresh_n > 0) fresh[fresh_n - 1].last = 1'b1;
    endfunction

    // Directed table: typed tokens only where they are plain to read
    function automatic row_t directed_row(input int i);
        case (i)
            0:  return {kt_pkg::OP_CHAR, 8'h2B, 1'b1, kt_pkg::KIND_OPER, kt_pkg::NO_KW,
                        16'd0, 7'd1, 1'b0, 1'b1};
            1:  return {kt_pkg::OP_CHAR, 8'h69, 1'b0, 32'd0};
            2:  return {kt_pkg::OP_CHAR, 8'h66, 1'b0, 32'd0};
            3:  return {kt_pkg::OP_CHAR, 8'h28, 1'b0, 32'd0};
            4:  return {kt_pkg::OP_CHAR, 8'hFF, 1'b0, 32'd0};
            5:  return {kt_pkg::OP_CHAR, 8'h00, 1'b0, 32'd0};
            6:  return {kt_pkg::OP_CHAR, 8'h39, 1'b0, 32'd0};
            7:  return {kt_pkg::OP_CHAR, 8'h30, 1'b0, 32'd0};
            8:  return {kt_pkg::OP_CHAR, 8'h09, 1'b1, kt_pkg::KIND_NUMBER, kt_pkg::NO_KW,
                        16'd6, 7'd2, 1'b0, 1'b1};
            9:  return {kt_pkg::OP_CHAR, QUOTE, 1'b0, 32'd0};
            10: return {kt_pkg::OP_CHAR, 8'h80, 1'b0, 32'd0};
            11: return {kt_pkg::OP_CHAR, QUOTE, 1'b1, kt_pkg::KIND_STRING, kt_pkg::NO_KW,
                        16'd10, 7'd1, 1'b0, 1'b1};
            12: return {kt_pkg::OP_CHAR, 8'h72, 1'b0, 32'd0};
            13: return {kt_pkg::OP_CHAR, 8'h65, 1'b0, 32'd0};
            14: return {kt_pkg::OP_CHAR, 8'h74, 1'b0, 32'd0};
            15: return {kt_pkg::OP_CHAR, 8'h75, 1'b0, 32'd0};
            16: return {kt_pkg::OP_CHAR, 8'h72, 1'b0, 32'd0};
            17: return {kt_pkg::OP_CHAR, 8'h6E, 1'b0, 32'd0};
            18: return {kt_pkg::OP_CHAR, 8'h7D, 1'b0, 32'd0};
            19: return {kt_pkg::OP_CHAR, 8'h5A, 1'b0, 32'd0};
            20: return {kt_pkg::OP_FLUSH, 8'hFF, 1'b1, kt_pkg::KIND_IDENT, kt_pkg::NO_KW,
                        16'd19, 7'd1, 1'b0, 1'b1};
            21: return {kt_pkg::OP_CHAR, QUOTE, 1'b0, 32'd0};
            22: return {kt_pkg::OP_CHAR, 8'h7F, 1'b0, 32'd0};
            23: return {kt_pkg::OP_FLUSH, 8'h00, 1'b1, kt_pkg::KIND_UNTERM, kt_pkg::NO_KW,
                        16'd1, 7'd1, 1'b0, 1'b1};
            default: return {kt_pkg::OP_FLUSH, 8'h00, 1'b0, 32'd0};
        endcase
    endfunction

    // Offer one item, wait for its transfer, then book the tokens it releases
    task automatic send_item(input logic op, input logic [7:0] ch, input logic typed,
                             input token_t want);
        kt_pkg::scan_mode_t was;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        was = lx_mode;
        scan_item(op, ch);
        if (typed) begin
            pending_tokens.push_back(want);
        end else begin
            for (int i = 0; i < fresh_n; i++) pending_tokens.push_back(fresh[i]);
        end
        n_items++;
        if (op == kt_pkg::OP_FLUSH) n_flush++;
        if (!(was == kt_pkg::MODE_IDLE && lx_mode == kt_pkg::MODE_IDLE && fresh_n == 0))
            n_live++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(kt_pkg::OP_CHAR, ch, 1'b0, '0);
    endtask

    task automatic send_flush();
        send_item(kt_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // Stop sending until every booked token has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_tokens.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] any_letter();
        return 8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25) : "A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? BLANK : 8'(9 + r);
    endfunction

    function automatic logic [7:0] any_op();
        case ($urandom_range(0, 6))
            0:       return "+";
            1:       return "-";
            2:       return "*";
            3:       return "/";
            4:       return "=";
            5:       return "<";
            default: return ">";
        endcase
    endfunction

    function automatic logic [7:0] any_bracket();
        case ($urandom_range(0, 3))
            0:       return "(";
            1:       return ")";
            2:       return "{";
            default: return "}";
        endcase
    endfunction

    function automatic logic [7:0] any_string_byte();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255)); while (ch == QUOTE);
        return ch;
    endfunction

    // One random token, well formed most of the time, and sometimes a separator after it
    task automatic random_token();
        int    r;
        int    n;
        int    cut;
        string name;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            // keyword, a prefix of one, a case-flipped one or one with a tail
            name = kw_name($urandom_range(0, kt_pkg::NUM_KW - 1));
            cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, name.len()) : name.len();
            for (int i = 0; i < cut; i++) begin
                if (i == 0 && $urandom_range(0, 7) == 0) send_char(8'(name[i] - 8'd32));
                else send_char(name[i]);
            end
            if ($urandom_range(0, 5) == 0) send_char($urandom_range(0, 1) ? any_letter() : any_digit());
        end else if (r < 40) begin
            n = $urandom_range(1, 8);
            send_char(any_letter());
            for (int i = 1; i < n; i++) send_char($urandom_range(0, 2) ? any_letter() : any_digit());
        end else if (r < 52) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) send_char(any_digit());
        end else if (r < 62) begin
            n = $urandom_range(0, 8);
            send_char(QUOTE);
            for (int i = 0; i < n; i++) send_char(any_string_byte());
            if ($urandom_range(0, 7) != 0) send_char(QUOTE);
        end else if (r < 75) begin
            send_char(any_op());
        end else if (r < 85) begin
            send_char(any_bracket());
        end else if (r < 88) begin
            // long token around the clip limit
            n = $urandom_range(CLIP_LEN - 2, CLIP_LEN + 6);
            case ($urandom_range(0, 2))
                0: begin
                    send_char(any_letter());
                    for (int i = 1; i < n; i++) send_char(any_letter());
                end
                1: for (int i = 0; i < n; i++) send_char(any_digit());
                default: begin
                    send_char(QUOTE);
                    for (int i = 0; i < n; i++) send_char(any_string_byte());
                    send_char(QUOTE);
                end
            endcase
        end else if (r < 94) begin
            send_char(8'($urandom_range(0, 255)));
        end else begin
            send_flush();
        end
        if ($urandom_range(0, 1)) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) send_char(any_blank());
        end
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            n_errors++;
        end
    endfunction

    // Hold the result side off in random bursts
    always @(posedge aclk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest booked token
    always @(posedge aclk) begin : watch_results
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $error("token with nothing booked: kind %0d start %0d", m_tuser, m_tdata[19:4]);
                n_errors++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", want.kind, m_tuser);
                check_field("keyword_id", want.kw, m_tdata[3:0]);
                check_field("start_position", want.start, m_tdata[19:4]);
                check_field("token_length", want.len, m_tdata[26:20]);
                check_field("overlong", want.over, m_tdata[27]);
                check_field("last_in_run", want.last, m_tlast);
                check_field("zero fill", 0, m_tdata[31:28]);
                n_checked++;
                if (want.kind <= kt_pkg::KIND_UNTERM) kind_seen[want.kind]++;
                if (want.over) n_overlong++;
            end
        end
    end

    initial begin
        row_t row;
        int   waited;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        clear_scanner();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= kt_pkg::OP_CHAR;
        m_tready <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (int i = 0; i < ROW_COUNT; i++) begin
            row = directed_row(i);
            send_item(row.op, row.ch, row.typed, row.want);
        end
        drain();

        // Random text, the last part without idling
        while (n_items < ITEM_GOAL) begin
            if (n_items >= CALM_FROM) calm = 1'b1;
            random_token();
        end
        send_flush();
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending_tokens.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (pending_tokens.size() != 0) begin
            $error("%0d tokens never came out", pending_tokens.size());
            n_errors++;
        end

        $display("Sent %0d items (%0d that moved the scanner, %0d flushes), checked %0d tokens.",
                 n_items, n_live, n_flush, n_checked);
        $display("Kinds kw/id/num/str/op/punct/unterm: %0d/%0d/%0d/%0d/%0d/%0d/%0d, clipped %0d.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5], kind_seen[6], n_overlong);
        if (n_errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #(64'd20_000_000);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
